// ----- hw/rtl/cdsb_pkg.sv -----
// ----------------------------------------------------------------------------
// cdsb_pkg
// Shared types and constants of the click detector and SOS blinker.
// ----------------------------------------------------------------------------
package cdsb_pkg;

  localparam int SYMBOLS_PER_LETTER = 3;
  localparam int TIMER_BITS         = 8;
  localparam int CFG_W              = 8;
  localparam int CMP_W              = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int SYM_COUNT          = 3 * SYMBOLS_PER_LETTER;
  localparam int SYM_W              = $clog2(SYM_COUNT + 1);
  localparam int CFG_IDX_W          = 3;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [SYM_W-1:0]      sym_idx_t;
  typedef logic [CFG_W-1:0]      cfg_val_t;

  localparam timer_t TIMER_MAX = {TIMER_BITS{1'b1}};

  localparam sym_idx_t SYM_DASH_FIRST = sym_idx_t'(SYMBOLS_PER_LETTER);
  localparam sym_idx_t SYM_DASH_END   = sym_idx_t'(2 * SYMBOLS_PER_LETTER);
  localparam sym_idx_t SYM_END        = sym_idx_t'(SYM_COUNT);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOT       = 3'd0,
    CFG_DASH      = 3'd1,
    CFG_DEBOUNCE  = 3'd2,
    CFG_WINDOW    = 3'd3,
    CFG_IDLE_POLL = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_WAIT_PRESS = 3'd0,
    PH_DEBOUNCE_1 = 3'd1,
    PH_RELEASE_1  = 3'd2,
    PH_WINDOW     = 3'd3,
    PH_DEBOUNCE_2 = 3'd4,
    PH_RELEASE_2  = 3'd5
  } click_phase_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2
  } click_ev_t;

  typedef struct packed {
    cfg_val_t dot_ticks;
    cfg_val_t dash_ticks;
    cfg_val_t debounce_ticks;
    cfg_val_t window_ticks;
    cfg_val_t idle_poll_ticks;
  } cfg_t;

  typedef struct packed {
    click_ev_t event_nxt;
    logic      active_cur;
    logic      active_nxt;
  } click_status_t;

  function automatic timer_t sat_inc(timer_t t);
    timer_t r;
    r = (t == TIMER_MAX) ? TIMER_MAX : t + timer_t'(1);
    return r;
  endfunction

  function automatic logic reached(timer_t t, cfg_val_t len);
    logic r;
    r = CMP_W'(t) >= CMP_W'(len);
    return r;
  endfunction

endpackage

// ----- hw/rtl/cdsb_click.sv -----
// ----------------------------------------------------------------------------
// cdsb_click
// Single and double click detector with debounce and the active flag.
// ----------------------------------------------------------------------------
module cdsb_click (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   pressed,
  input  cdsb_pkg::cfg_t         cfg,
  output cdsb_pkg::click_status_t status
);
  import cdsb_pkg::*;

  click_phase_t phase_r, phase_nxt;
  timer_t       timer_r, timer_nxt;
  logic         active_r, active_nxt;
  click_ev_t    ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT_PRESS;
      timer_r  <= '0;
      active_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      timer_r  <= timer_nxt;
      active_r <= active_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    ev        = EV_NONE;
    unique case (phase_r)
      PH_DEBOUNCE_1, PH_DEBOUNCE_2: begin
        timer_nxt = sat_inc(timer_r);
        if (reached(timer_nxt, cfg.debounce_ticks)) begin
          phase_nxt = (phase_r == PH_DEBOUNCE_1) ? PH_RELEASE_1 : PH_RELEASE_2;
        end
      end
      PH_RELEASE_1: begin
        if (!pressed) begin
          phase_nxt = PH_WINDOW;
          timer_nxt = '0;
        end
      end
      PH_WINDOW: begin
        if (pressed) begin
          timer_nxt = '0;
          phase_nxt = (cfg.debounce_ticks == '0) ? PH_RELEASE_2 : PH_DEBOUNCE_2;
        end else begin
          timer_nxt = sat_inc(timer_r);
          if (reached(timer_nxt, cfg.window_ticks)) begin
            phase_nxt = PH_WAIT_PRESS;
            timer_nxt = '0;
            ev        = EV_SINGLE;
          end
        end
      end
      PH_RELEASE_2: begin
        if (!pressed) begin
          phase_nxt = PH_WAIT_PRESS;
          timer_nxt = '0;
          ev        = EV_DOUBLE;
        end
      end
      default: begin
        phase_nxt = PH_WAIT_PRESS;
        if (pressed) begin
          timer_nxt = '0;
          phase_nxt = (cfg.debounce_ticks == '0) ? PH_RELEASE_1 : PH_DEBOUNCE_1;
        end
      end
    endcase

    priority case (ev)
      EV_SINGLE: active_nxt = 1'b1;
      EV_DOUBLE: active_nxt = 1'b0;
      default:   active_nxt = active_r;
    endcase
  end

  assign status.event_nxt  = ev;
  assign status.active_cur = active_r;
  assign status.active_nxt = active_nxt;

endmodule

// ----- hw/rtl/cdsb_blinker.sv -----
// ----------------------------------------------------------------------------
// cdsb_blinker
// SOS sequencer: idle polling of the active flag and dot/dash phase timing.
// ----------------------------------------------------------------------------
module cdsb_blinker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  cdsb_pkg::cfg_t         cfg,
  input  cdsb_pkg::click_status_t status,
  output logic                   led_nxt
);
  import cdsb_pkg::*;

  sym_idx_t idx_r, idx_nxt, idx_inc;
  logic     lit_r, lit_nxt;
  timer_t   phase_tmr_r, phase_tmr_nxt, phase_inc;
  logic     run_r, run_nxt;
  timer_t   idle_tmr_r, idle_tmr_nxt, idle_inc;
  logic     led_r, led_seq;
  logic     is_dash;
  cfg_val_t len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      lit_r       <= 1'b0;
      phase_tmr_r <= '0;
      run_r       <= 1'b0;
      idle_tmr_r  <= '0;
      led_r       <= 1'b0;
    end else if (step) begin
      idx_r       <= idx_nxt;
      lit_r       <= lit_nxt;
      phase_tmr_r <= phase_tmr_nxt;
      run_r       <= run_nxt;
      idle_tmr_r  <= idle_tmr_nxt;
      led_r       <= led_nxt;
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    lit_nxt       = lit_r;
    phase_tmr_nxt = phase_tmr_r;
    run_nxt       = run_r;
    idle_tmr_nxt  = idle_tmr_r;
    led_seq       = led_r;
    is_dash       = (idx_r >= SYM_DASH_FIRST) && (idx_r < SYM_DASH_END);
    len           = is_dash ? cfg.dash_ticks : cfg.dot_ticks;
    idx_inc       = idx_r + sym_idx_t'(1);
    phase_inc     = sat_inc(phase_tmr_r);
    idle_inc      = sat_inc(idle_tmr_r);

    if (!run_r) begin
      idle_tmr_nxt = idle_inc;
      if (reached(idle_inc, cfg.idle_poll_ticks)) begin
        idle_tmr_nxt = '0;
        if (status.active_cur) begin
          run_nxt       = 1'b1;
          idx_nxt       = '0;
          lit_nxt       = 1'b1;
          phase_tmr_nxt = '0;
          led_seq       = 1'b1;
        end
      end
    end else begin
      phase_tmr_nxt = phase_inc;
      if (reached(phase_inc, len)) begin
        phase_tmr_nxt = '0;
        if (lit_r) begin
          lit_nxt = 1'b0;
          led_seq = 1'b0;
        end else if (idx_inc >= SYM_END) begin
          run_nxt      = 1'b0;
          idx_nxt      = '0;
          idle_tmr_nxt = '0;
          if (status.active_cur) begin
            run_nxt = 1'b1;
            lit_nxt = 1'b1;
            led_seq = 1'b1;
          end
        end else begin
          idx_nxt = idx_inc;
          lit_nxt = 1'b1;
          led_seq = 1'b1;
        end
      end
    end

    led_nxt = (status.event_nxt == EV_DOUBLE) ? 1'b0 : led_seq;
  end

endmodule

// ----- hw/rtl/click_detect_sos_blinker_unit.sv -----
// ----------------------------------------------------------------------------
// click_detect_sos_blinker_unit
// Each input word is one 10 ms poll tick carrying the raw active-low button
// level. Each tick produces exactly one output word: the LED level, the
// click event of that tick (none, single or double) and the SOS enable flag.
// A single click enables the SOS blinker, a double click disables it and
// turns the LED off at once; a sequence already started plays to its end.
// The tick update is combinational between the state registers and the
// output register, so one word can be accepted every cycle while in_ready
// is high, that is whenever the output register is empty or is being
// drained in the same cycle, so a stalled receiver holds off the input only
// while its result waits. The user writes the timing registers through the
// cfg_ port only while the unit is idle, which the unit does not enforce;
// writes take effect on the next tick. Synchronous reset restores the
// default timings, clears all state and empties the output register.
// ----------------------------------------------------------------------------
module click_detect_sos_blinker_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_button_level,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_led_on,
  output logic [1:0]                 out_click_event,
  output logic                       out_active,
  input  logic                       cfg_we,
  input  logic [cdsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cdsb_pkg::CFG_W-1:0] cfg_wdata
);
  import cdsb_pkg::*;

  cfg_t          cfg_r;
  click_status_t status;
  logic          step;
  logic          led_nxt;
  logic          out_valid_r;
  logic          led_r;
  click_ev_t     ev_r;
  logic          active_r;

  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dot_ticks       <= 8'd20;
      cfg_r.dash_ticks      <= 8'd50;
      cfg_r.debounce_ticks  <= 8'd5;
      cfg_r.window_ticks    <= 8'd60;
      cfg_r.idle_poll_ticks <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DOT:       cfg_r.dot_ticks       <= cfg_wdata;
        CFG_DASH:      cfg_r.dash_ticks      <= cfg_wdata;
        CFG_DEBOUNCE:  cfg_r.debounce_ticks  <= cfg_wdata;
        CFG_WINDOW:    cfg_r.window_ticks    <= cfg_wdata;
        CFG_IDLE_POLL: cfg_r.idle_poll_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cdsb_click u_click (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .pressed (!in_button_level),
    .cfg     (cfg_r),
    .status  (status)
  );

  cdsb_blinker u_blinker (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .cfg     (cfg_r),
    .status  (status),
    .led_nxt (led_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      led_r    <= led_nxt;
      ev_r     <= status.event_nxt;
      active_r <= status.active_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_on      = led_r;
  assign out_click_event = ev_r;
  assign out_active      = active_r;

endmodule

// ----- test/click_detect_sos_blinker_unit_tb.sv -----
// ----------------------------------------------------------------------------
// click_detect_sos_blinker_unit_tb
// Drives button poll ticks into the click detector and SOS blinker and checks
// every result word against a tick-by-tick prediction of the LED level, the
// click event and the enable flag. The run covers directed clicks, zero and
// full-scale timings and random click gestures, with idling on both sides.
// ----------------------------------------------------------------------------
module click_detect_sos_blinker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdsb_pkg::*;

  typedef struct {
    logic      led_on;
    click_ev_t click_event;
    logic      active;
  } tick_word_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  localparam cfg_t CFG_AT_RESET = '{dot_ticks: 8'd20, dash_ticks: 8'd50,
    debounce_ticks: 8'd5, window_ticks: 8'd60, idle_poll_ticks: 8'd10};
  localparam cfg_t CFG_FAST = '{dot_ticks: 8'd1, dash_ticks: 8'd2,
    debounce_ticks: 8'd0, window_ticks: 8'd2, idle_poll_ticks: 8'd1};
  localparam cfg_t CFG_ZERO = '{dot_ticks: 8'd0, dash_ticks: 8'd0,
    debounce_ticks: 8'd0, window_ticks: 8'd0, idle_poll_ticks: 8'd0};
  localparam cfg_t CFG_FULL = '{dot_ticks: 8'd255, dash_ticks: 8'd255,
    debounce_ticks: 8'd255, window_ticks: 8'd255, idle_poll_ticks: 8'd255};

  class sos_tick_scoreboard;
    cfg_t         sets;
    click_phase_t phase;
    timer_t       click_t;
    logic         active;
    int           sym_pos;
    logic         lit;
    timer_t       phase_t;
    logic         running;
    timer_t       idle_t;
    logic         led;
    tick_word_t   expected_words[$];
    int           errors;
    int           checked;

    function new();
      sets    = CFG_AT_RESET;
      phase   = PH_WAIT_PRESS;
      click_t = '0;
      active  = 1'b0;
      sym_pos = 0;
      lit     = 1'b0;
      phase_t = '0;
      running = 1'b0;
      idle_t  = '0;
      led     = 1'b0;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, cfg_val_t v);
      case (idx)
        CFG_DOT:       sets.dot_ticks = v;
        CFG_DASH:      sets.dash_ticks = v;
        CFG_DEBOUNCE:  sets.debounce_ticks = v;
        CFG_WINDOW:    sets.window_ticks = v;
        CFG_IDLE_POLL: sets.idle_poll_ticks = v;
        default: ;
      endcase
    endfunction

    function timer_t bump(timer_t t);
      return (t == TIMER_MAX) ? t : t + 1'b1;
    endfunction

    function void begin_sos();
      running = 1'b1;
      sym_pos = 0;
      lit     = 1'b1;
      phase_t = '0;
      led     = 1'b1;
    endfunction

    function void step_blinker();
      cfg_val_t len;
      if (!running) begin
        idle_t = bump(idle_t);
        if (idle_t >= sets.idle_poll_ticks) begin
          idle_t = '0;
          if (active) begin_sos();
        end
        return;
      end
      len = (sym_pos >= SYMBOLS_PER_LETTER && sym_pos < 2 * SYMBOLS_PER_LETTER) ?
            sets.dash_ticks : sets.dot_ticks;
      phase_t = bump(phase_t);
      if (phase_t < len) return;
      phase_t = '0;
      if (lit) begin
        lit = 1'b0;
        led = 1'b0;
        return;
      end
      sym_pos++;
      if (sym_pos >= SYM_COUNT) begin
        running = 1'b0;
        sym_pos = 0;
        idle_t  = '0;
        if (active) begin_sos();
      end else begin
        lit = 1'b1;
        led = 1'b1;
      end
    endfunction

    function click_ev_t step_click(logic pressed);
      case (phase)
        PH_DEBOUNCE_1, PH_DEBOUNCE_2: begin
          click_t = bump(click_t);
          if (click_t >= sets.debounce_ticks)
            phase = (phase == PH_DEBOUNCE_1) ? PH_RELEASE_1 : PH_RELEASE_2;
          return EV_NONE;
        end
        PH_RELEASE_1: begin
          if (!pressed) begin
            phase   = PH_WINDOW;
            click_t = '0;
          end
          return EV_NONE;
        end
        PH_WINDOW: begin
          if (pressed) begin
            click_t = '0;
            phase   = (sets.debounce_ticks == 0) ? PH_RELEASE_2 : PH_DEBOUNCE_2;
            return EV_NONE;
          end
          click_t = bump(click_t);
          if (click_t >= sets.window_ticks) begin
            phase   = PH_WAIT_PRESS;
            click_t = '0;
            return EV_SINGLE;
          end
          return EV_NONE;
        end
        PH_RELEASE_2: begin
          if (!pressed) begin
            phase   = PH_WAIT_PRESS;
            click_t = '0;
            return EV_DOUBLE;
          end
          return EV_NONE;
        end
        default: begin
          phase = PH_WAIT_PRESS;
          if (pressed) begin
            click_t = '0;
            phase   = (sets.debounce_ticks == 0) ? PH_RELEASE_1 : PH_DEBOUNCE_1;
          end
          return EV_NONE;
        end
      endcase
    endfunction

    function void advance_tick(logic level);
      click_ev_t  ev;
      tick_word_t w;
      step_blinker();
      ev = step_click(!level);
      if (ev == EV_SINGLE) begin
        active = 1'b1;
      end else if (ev == EV_DOUBLE) begin
        active = 1'b0;
        led    = 1'b0;
      end
      w.led_on      = led;
      w.click_event = ev;
      w.active      = active;
      expected_words.push_back(w);
    endfunction

    function void note_button(logic level);
      advance_tick(level);
    endfunction

    task report(string what);
      $display("%0t ns: word %0d: %s", $time, checked, what);
      errors++;
    endtask

    task check_word(logic led_got, logic [1:0] ev_got, logic active_got);
      tick_word_t w;
      if (expected_words.size() == 0) begin
        report("result word arrived with nothing expected");
        return;
      end
      w = expected_words.pop_front();
      if (led_got !== w.led_on)
        report($sformatf("led_on got %b want %b", led_got, w.led_on));
      if (ev_got !== w.click_event)
        report($sformatf("click_event got %0d want %0d", ev_got, w.click_event));
      if (active_got !== w.active)
        report($sformatf("active got %b want %b", active_got, w.active));
      checked++;
    endtask
  endclass

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  logic                 in_button_level = 1'b1;
  logic                 out_valid;
  logic                 out_ready       = 1'b0;
  logic                 out_led_on;
  logic [1:0]           out_click_event;
  logic                 out_active;
  logic                 cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = CFG_DOT;
  cfg_val_t             cfg_wdata       = '0;

  sos_tick_scoreboard sb;
  cfg_t               cur = CFG_AT_RESET;
  int                 send_idle_pct = 18;
  int                 recv_idle_pct = 80;
  int                 items_left = 0;
  bit                 hold_req = 1'b0;
  int                 hold_left = 0;

  click_detect_sos_blinker_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_button_level (in_button_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_led_on      (out_led_on),
    .out_click_event (out_click_event),
    .out_active      (out_active),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_button(in_button_level);
      if (out_valid && out_ready) sb.check_word(out_led_on, out_click_event, out_active);
    end
  end

  // The long hold-off lets the output register fill so that in_ready drops.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 60;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_word(input logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_button_level <= level;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_run(input logic level, input int n);
    for (int i = 0; i < n && items_left > 0; i++) begin
      send_word(level);
      items_left--;
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic apply_settings(input cfg_t c, input bit with_spare);
    cfg_idx_t order[5];
    cfg_val_t vals[5];
    order = '{CFG_DOT, CFG_DASH, CFG_DEBOUNCE, CFG_WINDOW, CFG_IDLE_POLL};
    vals  = '{c.dot_ticks, c.dash_ticks, c.debounce_ticks, c.window_ticks,
              c.idle_poll_ticks};
    if (with_spare) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_SPARE;
      cfg_wdata <= cfg_val_t'($urandom_range(255));
      @(negedge clk);
    end
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= vals[i];
      sb.write_reg(order[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cur = c;
  endtask

  function automatic cfg_val_t pick_len();
    return ($urandom_range(99) < 10) ? cfg_val_t'($urandom_range(255)) :
                                       cfg_val_t'($urandom_range(8));
  endfunction

  // One button gesture: mostly well-formed single or double clicks with
  // random press lengths and gaps, sometimes a long release or noise.
  task automatic play_gesture();
    int deb;
    int win;
    int pick;
    deb  = cur.debounce_ticks;
    win  = cur.window_ticks;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_run(1'b0, $urandom_range(1, deb + 3));
      send_run(1'b1, win + $urandom_range(1, 4));
    end else if (pick < 75) begin
      send_run(1'b0, $urandom_range(1, deb + 3));
      send_run(1'b1, $urandom_range(1, (win > 0) ? win : 1));
      send_run(1'b0, $urandom_range(1, deb + 3));
      send_run(1'b1, $urandom_range(1, 6));
    end else if (pick < 90) begin
      send_run(1'b1, $urandom_range(1, 40));
    end else begin
      for (int i = $urandom_range(1, 12); i > 0 && items_left > 0; i--) begin
        send_word(logic'($urandom_range(1)));
        items_left--;
      end
    end
  endtask

  initial begin
    cfg_t phase_cfg;
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    items_left = 25;
    send_run(1'b1, 2);
    send_run(1'b0, 7);
    send_run(1'b1, 2);
    quiesce();
    apply_settings(CFG_FAST, 1'b0);
    send_run(1'b0, 1);
    send_run(1'b1, 3);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 3);

    for (int p = 0; p < 8; p++) begin
      quiesce();
      case (p)
        0:       phase_cfg = CFG_ZERO;
        2:       phase_cfg = CFG_FULL;
        default: phase_cfg = '{dot_ticks: pick_len(), dash_ticks: pick_len(),
                   debounce_ticks: pick_len(), window_ticks: pick_len(),
                   idle_poll_ticks: pick_len()};
      endcase
      send_idle_pct = (p < 3) ? 18 : (p < 6) ? 80 : 0;
      recv_idle_pct = (p < 3) ? 80 : (p < 6) ? 18 : 0;
      apply_settings(phase_cfg, p == 1);
      if (p == 1 || p == 4) hold_req = 1'b1;
      items_left = (p == 2) ? 300 : 115;
      while (items_left > 0) play_gesture();
    end

    quiesce();
    repeat (5) @(negedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
